### rtl/core/ctt_pkg.sv
// ctt_pkg: shared types, constants and character-class helpers for the
// config text tokenizer; no dependencies, imported by every rtl/core module
package ctt_pkg;

  localparam int LINE_BITS_DEF  = 32;  // default width of the line counter
  localparam int LINE_OUT_BITS  = 32;  // width of the reported line number
  localparam int ACC_BITS       = 64;  // number accumulator width
  localparam int QUEUE_DEPTH    = 4;   // result queue entries
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_IDENT = 4'd1,
    MODE_DEC   = 4'd2,
    MODE_ZERO  = 4'd3,
    MODE_HEX   = 4'd4,
    MODE_STR   = 4'd5,
    MODE_ESC   = 4'd6,
    MODE_SLASH = 4'd7,
    MODE_CMT   = 4'd8
  } mode_t;

  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_BOOL   = 3'd1;
  localparam logic [2:0] KIND_NUMBER = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_PUNCT  = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               token_kind;
    logic [7:0]               token_char;
    logic                     char_valid;
    logic [ACC_BITS-1:0]      number_value;
    logic [LINE_OUT_BITS-1:0] line_number;
    logic                     token_end;
  } out_item_t;

  // results of one byte: how many, and up to two of them in order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } lex_res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == "{" || c == "}" || c == ":" || c == "," || c == "[" || c == "]" ||
           c == ">" || c == "<" || c == "+" || c == "-" || c == "*" || c == "(" ||
           c == ")";
  endfunction

  // nibble value of a hex digit character
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[3:0] + ((c >= "A") ? 4'd9 : 4'd0);
  endfunction

  function automatic logic [7:0] kw_true_char(input logic [1:0] p);
    logic [7:0] ch;
    case (p)
      2'd0:    ch = "t";
      2'd1:    ch = "r";
      2'd2:    ch = "u";
      default: ch = "e";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_false_char(input logic [2:0] p);
    logic [7:0] ch;
    case (p)
      3'd0:    ch = "f";
      3'd1:    ch = "a";
      3'd2:    ch = "l";
      3'd3:    ch = "s";
      default: ch = "e";
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/ctt_lex.sv
// ctt_lex: lexer state registers and the per-byte transition logic
// depends on ctt_pkg
module ctt_lex
  import ctt_pkg::*;
#(
  parameter int LINE_COUNT_BITS = LINE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t item,
  output lex_res_t res
);

  mode_t                      mode_r, mode_nxt;
  logic [ACC_BITS-1:0]        acc_r, acc_nxt;
  logic                       hex_seen_r, hex_seen_nxt;
  logic [2:0]                 kpos_r, kpos_nxt;
  logic [1:0]                 kcand_r, kcand_nxt;
  logic [LINE_COUNT_BITS-1:0] cur_line_r, cur_line_nxt;
  logic [LINE_COUNT_BITS-1:0] start_line_r, start_line_nxt;

  logic [LINE_OUT_BITS-1:0] fin_line, new_line;
  logic [7:0]               c;
  logic                     do_fin, relex, do_new, fin_emits;
  out_item_t                fin_item, new_item;
  logic [2:0]               new_kind;
  logic [7:0]               new_char;
  logic                     new_cvalid, new_end;
  logic [LINE_COUNT_BITS-1:0] line_inc;

  assign c        = item.text_byte;
  assign line_inc = (cur_line_r != '1) ? cur_line_r + LINE_COUNT_BITS'(1) : cur_line_r;

  // saturate line counters to the reported width
  generate
    if (LINE_COUNT_BITS <= LINE_OUT_BITS) begin : g_line_narrow
      assign fin_line = LINE_OUT_BITS'(start_line_r);
      assign new_line = LINE_OUT_BITS'(start_line_nxt);
    end else begin : g_line_wide
      assign fin_line = (|start_line_r[LINE_COUNT_BITS-1:LINE_OUT_BITS]) ? '1 :
                        start_line_r[LINE_OUT_BITS-1:0];
      assign new_line = (|start_line_nxt[LINE_COUNT_BITS-1:LINE_OUT_BITS]) ? '1 :
                        start_line_nxt[LINE_OUT_BITS-1:0];
    end
  endgenerate

  // token that the current mode closes when it ends
  always_comb begin
    fin_item             = '0;
    fin_item.line_number = fin_line;
    fin_item.token_end   = 1'b1;
    fin_emits            = 1'b1;
    case (mode_r)
      MODE_IDENT: begin
        if (kcand_r[0] && kpos_r == 3'd4) begin
          fin_item.token_kind   = KIND_BOOL;
          fin_item.number_value = ACC_BITS'(1);
        end else if (kcand_r[1] && kpos_r == 3'd5) begin
          fin_item.token_kind = KIND_BOOL;
        end else begin
          fin_item.token_kind = KIND_IDENT;
        end
      end
      MODE_DEC, MODE_ZERO: begin
        fin_item.token_kind   = KIND_NUMBER;
        fin_item.number_value = acc_r;
      end
      MODE_HEX: begin
        if (hex_seen_r) begin
          fin_item.token_kind   = KIND_NUMBER;
          fin_item.number_value = acc_r;
        end else begin
          fin_item.token_kind = KIND_ERROR;
        end
      end
      MODE_STR, MODE_ESC: fin_item.token_kind = KIND_STRING;
      MODE_SLASH: begin
        fin_item.token_kind = KIND_PUNCT;
        fin_item.token_char = "/";
        fin_item.char_valid = 1'b1;
      end
      default: fin_emits = 1'b0;
    endcase
  end

  // next state and the byte's own result
  always_comb begin
    mode_nxt       = mode_r;
    acc_nxt        = acc_r;
    hex_seen_nxt   = hex_seen_r;
    kpos_nxt       = kpos_r;
    kcand_nxt      = kcand_r;
    cur_line_nxt   = cur_line_r;
    start_line_nxt = start_line_r;
    do_fin         = 1'b0;
    relex          = 1'b0;
    do_new         = 1'b0;
    new_kind       = KIND_IDENT;
    new_char       = 8'd0;
    new_cvalid     = 1'b0;
    new_end        = 1'b0;

    if (item.end_of_text) begin
      do_fin   = 1'b1;
      mode_nxt = MODE_IDLE;
    end else begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_" || c == "-") begin
            kcand_nxt[0] = kcand_r[0] && kpos_r < 3'd4 && c == kw_true_char(kpos_r[1:0]);
            kcand_nxt[1] = kcand_r[1] && kpos_r < 3'd5 && c == kw_false_char(kpos_r);
            kpos_nxt     = (kpos_r == 3'd7) ? kpos_r : kpos_r + 3'd1;
            do_new       = 1'b1;
            new_kind     = KIND_IDENT;
            new_char     = c;
            new_cvalid   = 1'b1;
          end else begin
            relex = 1'b1;
          end
        end
        MODE_DEC: begin
          if (is_digit(c)) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + ACC_BITS'(c[3:0]);
          end else begin
            relex = 1'b1;
          end
        end
        MODE_ZERO: begin
          if (c == "x" || c == "X") begin
            mode_nxt     = MODE_HEX;
            hex_seen_nxt = 1'b0;
            acc_nxt      = '0;
          end else begin
            relex = 1'b1;
          end
        end
        MODE_HEX: begin
          if (is_hex(c)) begin
            acc_nxt      = {acc_r[ACC_BITS-5:0], hex_val(c)};
            hex_seen_nxt = 1'b1;
          end else begin
            relex = 1'b1;
          end
        end
        MODE_STR: begin
          if (c == "\"") begin
            do_fin   = 1'b1;
            mode_nxt = MODE_IDLE;
          end else if (c == "\\") begin
            mode_nxt = MODE_ESC;
          end else begin
            if (c == "\n") cur_line_nxt = line_inc;
            do_new     = 1'b1;
            new_kind   = KIND_STRING;
            new_char   = c;
            new_cvalid = 1'b1;
          end
        end
        MODE_ESC: begin
          case (c)
            "n":     new_char = 8'h0A;
            "r":     new_char = 8'h0D;
            "f":     new_char = 8'h0C;
            "t":     new_char = 8'h09;
            default: new_char = c;
          endcase
          if (c == "\n") cur_line_nxt = line_inc;
          do_new     = 1'b1;
          new_kind   = KIND_STRING;
          new_cvalid = 1'b1;
          mode_nxt   = MODE_STR;
        end
        MODE_SLASH: begin
          if (c == "/") begin
            mode_nxt = MODE_CMT;
          end else begin
            relex = 1'b1;
          end
        end
        MODE_CMT: begin
          if (c == "\n") begin
            cur_line_nxt = line_inc;
            mode_nxt     = MODE_IDLE;
          end
        end
        default: relex = 1'b1;
      endcase

      // pending token closes, then the byte starts afresh
      if (relex) begin
        do_fin   = 1'b1;
        mode_nxt = MODE_IDLE;
        if (c == "\n") begin
          cur_line_nxt = line_inc;
        end else if (c != "\t" && c != "\r" && c != " ") begin
          start_line_nxt = cur_line_r;
          if (is_alpha(c) || c == "_") begin
            mode_nxt   = MODE_IDENT;
            kpos_nxt   = 3'd1;
            kcand_nxt  = {c == "f", c == "t"};
            do_new     = 1'b1;
            new_kind   = KIND_IDENT;
            new_char   = c;
            new_cvalid = 1'b1;
          end else if (is_digit(c)) begin
            acc_nxt  = ACC_BITS'(c[3:0]);
            mode_nxt = (c == "0") ? MODE_ZERO : MODE_DEC;
          end else if (c == "\"") begin
            mode_nxt = MODE_STR;
          end else if (is_punct(c)) begin
            do_new     = 1'b1;
            new_kind   = KIND_PUNCT;
            new_char   = c;
            new_cvalid = 1'b1;
            new_end    = 1'b1;
          end else if (c == "/") begin
            mode_nxt = MODE_SLASH;
          end else begin
            do_new   = 1'b1;
            new_kind = KIND_ERROR;
            new_end  = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    new_item              = '0;
    new_item.token_kind   = new_kind;
    new_item.token_char   = new_char;
    new_item.char_valid   = new_cvalid;
    new_item.line_number  = new_line;
    new_item.token_end    = new_end;
  end

  always_comb begin
    if (do_fin && fin_emits) begin
      res.count  = do_new ? 2'd2 : 2'd1;
      res.first  = fin_item;
    end else begin
      res.count  = do_new ? 2'd1 : 2'd0;
      res.first  = new_item;
    end
    res.second = new_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      acc_r        <= '0;
      hex_seen_r   <= 1'b0;
      kpos_r       <= 3'd0;
      kcand_r      <= 2'b11;
      cur_line_r   <= LINE_COUNT_BITS'(1);
      start_line_r <= LINE_COUNT_BITS'(1);
    end else if (accept) begin
      mode_r       <= mode_nxt;
      acc_r        <= acc_nxt;
      hex_seen_r   <= hex_seen_nxt;
      kpos_r       <= kpos_nxt;
      kcand_r      <= kcand_nxt;
      cur_line_r   <= cur_line_nxt;
      start_line_r <= start_line_nxt;
    end
  end

endmodule

### rtl/core/ctt_queue.sv
// ctt_queue: small result queue taking up to two results a cycle and
// giving one per transfer; depends on ctt_pkg
module ctt_queue
  import ctt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_en,
  input  lex_res_t  push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [QUEUE_CNT_BITS-1:0] count_r, count_nxt, push_cnt;
  logic                      pop;

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[head_r];
  assign pop       = out_valid && !out_stall;
  // room must exist for the worst case of two results
  assign full      = count_r > QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
  assign push_cnt  = push_en ? QUEUE_CNT_BITS'(push.count) : '0;

  always_comb begin
    tail_nxt  = tail_r + QUEUE_PTR_BITS'(push_cnt);
    head_nxt  = pop ? head_r + QUEUE_PTR_BITS'(1) : head_r;
    count_nxt = count_r + push_cnt - QUEUE_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_en && push.count != 2'd0) begin
      mem_r[tail_r] <= push.first;
    end
    if (push_en && push.count == 2'd2) begin
      mem_r[tail_r + QUEUE_PTR_BITS'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### rtl/core/config_text_tokenizer_core.sv
// config_text_tokenizer_core: top level of the byte-serial config text lexer
// depends on ctt_pkg, ctt_lex and ctt_queue
//
// usage
//   in channel: one text byte per transfer (in_data.text_byte); a transfer
//   with in_data.end_of_text set ignores the byte, flushes any pending token
//   and puts the lexer back to idle (line count is kept)
//   out channel: one token result per transfer; identifiers and strings give
//   one result per character and a closing result with token_end set;
//   numbers, punctuation and errors give a single closing result
//   a byte's results are queued on its transfer and offered behind older ones
//   throughput: one byte per cycle while in_stall is low; a byte that closes
//   one token and starts another gives two results, which the out side drains
//   one per transfer from the single-read result queue
//   in_stall rises when the 4-entry result queue lacks room for two results
//   out_stall holds the offered result steady; bytes keep flowing in until
//   the queue fills
//   reset (rst_n low, synchronous) empties the queue, returns the lexer to
//   idle and sets the line counter to one
module config_text_tokenizer_core
  import ctt_pkg::*;
#(
  parameter int LINE_COUNT_BITS = LINE_BITS_DEF  // line counter width, 8 to 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     in_accept;  // byte transfer this cycle
  lex_res_t lex_res;    // results produced by the byte

  assign in_accept = in_valid && !in_stall;

  // mode, number accumulator, keyword tracker and line counters
  ctt_lex #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_lex (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .res    (lex_res)
  );

  // results wait here, which keeps the in side moving while out stalls
  ctt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (in_accept),
    .push      (lex_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### dv/ctt_check_pkg.sv
`timescale 1ns / 100ps
// ctt_check_pkg: token scoreboard for the config text tokenizer testbench
// holds a byte-level lexer prediction and the queue of tokens still due
// depends on ctt_pkg for the transfer structs, lexer modes and token kinds
package ctt_check_pkg;
  import ctt_pkg::*;

  class token_scoreboard;
    localparam logic [7:0] NL  = 8'h0A;
    localparam logic [7:0] TAB = 8'h09;
    localparam logic [7:0] CR  = 8'h0D;
    localparam logic [7:0] FF  = 8'h0C;

    mode_t       mode;
    logic [63:0] acc;
    bit          hex_seen;
    int unsigned kw_pos;
    bit [1:0]    kw_live;      // bit 0: still "true", bit 1: still "false"
    logic [63:0] cur_line;
    logic [63:0] start_line;
    logic [63:0] line_max;
    out_item_t   expected_tokens[$];
    int unsigned failures;

    function new(int line_bits);
      line_max = (line_bits >= 64) ? '1 : ((64'd1 << line_bits) - 64'd1);
      failures = 0;
      reset_lexer();
    endfunction

    function void reset_lexer();
      mode       = MODE_IDLE;
      acc        = '0;
      hex_seen   = 1'b0;
      kw_pos     = 0;
      kw_live    = 2'b11;
      cur_line   = 64'd1;
      start_line = 64'd1;
      expected_tokens.delete();
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    local function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    local function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    local function bit hex_char(logic [7:0] c);
      return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    local function logic [3:0] nibble_of(logic [7:0] c);
      if (c >= "a") return 4'(c - "a" + 8'd10);
      if (c >= "A") return 4'(c - "A" + 8'd10);
      return c[3:0];
    endfunction

    local function bit punct_char(logic [7:0] c);
      string marks;
      marks = "{}:,[]<>+-*()";
      for (int i = 0; i < marks.len(); i++) begin
        if (marks[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    local function void next_line();
      if (cur_line < line_max) cur_line++;
    endfunction

    local function void push_token(logic [2:0] kind, logic [7:0] ch, bit has_ch,
                                   logic [63:0] value, bit last);
      out_item_t t;
      t.token_kind   = kind;
      t.token_char   = has_ch ? ch : 8'd0;
      t.char_valid   = has_ch;
      t.number_value = value;
      t.line_number  = (start_line > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : start_line[31:0];
      t.token_end    = last;
      expected_tokens.push_back(t);
    endfunction

    local function void track_keyword(logic [7:0] c);
      string word_t;
      string word_f;
      word_t = "true";
      word_f = "false";
      if (kw_pos >= 4 || word_t[kw_pos] != c) kw_live[0] = 1'b0;
      if (kw_pos >= 5 || word_f[kw_pos] != c) kw_live[1] = 1'b0;
      if (kw_pos < 7) kw_pos++;
    endfunction

    // emit the closing token of whatever is pending, then go idle
    local function void close_token();
      case (mode)
        MODE_IDENT: begin
          if (kw_live[0] && kw_pos == 4)
            push_token(KIND_BOOL, 8'd0, 1'b0, 64'd1, 1'b1);
          else if (kw_live[1] && kw_pos == 5)
            push_token(KIND_BOOL, 8'd0, 1'b0, 64'd0, 1'b1);
          else
            push_token(KIND_IDENT, 8'd0, 1'b0, 64'd0, 1'b1);
        end
        MODE_DEC, MODE_ZERO: push_token(KIND_NUMBER, 8'd0, 1'b0, acc, 1'b1);
        MODE_HEX: begin
          if (hex_seen) push_token(KIND_NUMBER, 8'd0, 1'b0, acc, 1'b1);
          else push_token(KIND_ERROR, 8'd0, 1'b0, 64'd0, 1'b1);
        end
        MODE_STR, MODE_ESC: push_token(KIND_STRING, 8'd0, 1'b0, 64'd0, 1'b1);
        MODE_SLASH: push_token(KIND_PUNCT, "/", 1'b1, 64'd0, 1'b1);
        default: ;
      endcase
      mode = MODE_IDLE;
    endfunction

    // byte seen while idle
    local function void open_token(logic [7:0] c);
      if (c == NL) begin
        next_line();
        return;
      end
      if (c == TAB || c == CR || c == " ") return;
      start_line = cur_line;
      if (letter(c) || c == "_") begin
        mode    = MODE_IDENT;
        kw_pos  = 0;
        kw_live = 2'b11;
        track_keyword(c);
        push_token(KIND_IDENT, c, 1'b1, 64'd0, 1'b0);
      end else if (digit(c)) begin
        acc  = 64'(c - "0");
        mode = (c == "0") ? MODE_ZERO : MODE_DEC;
      end else if (c == "\"") begin
        mode = MODE_STR;
      end else if (punct_char(c)) begin
        push_token(KIND_PUNCT, c, 1'b1, 64'd0, 1'b1);
      end else if (c == "/") begin
        mode = MODE_SLASH;
      end else begin
        push_token(KIND_ERROR, 8'd0, 1'b0, 64'd0, 1'b1);
      end
    endfunction

    function void note_byte(in_item_t item);
      logic [7:0] c;
      logic [7:0] ch;
      c = item.text_byte;
      if (item.end_of_text) begin
        close_token();
        return;
      end
      case (mode)
        MODE_IDENT: begin
          if (letter(c) || digit(c) || c == "_" || c == "-") begin
            track_keyword(c);
            push_token(KIND_IDENT, c, 1'b1, 64'd0, 1'b0);
            return;
          end
        end
        MODE_DEC: begin
          if (digit(c)) begin
            acc = acc * 64'd10 + 64'(c - "0");
            return;
          end
        end
        MODE_ZERO: begin
          if (c == "x" || c == "X") begin
            mode     = MODE_HEX;
            hex_seen = 1'b0;
            acc      = '0;
            return;
          end
        end
        MODE_HEX: begin
          if (hex_char(c)) begin
            acc      = {acc[59:0], nibble_of(c)};
            hex_seen = 1'b1;
            return;
          end
        end
        MODE_STR: begin
          if (c == "\"") begin
            close_token();
          end else if (c == "\\") begin
            mode = MODE_ESC;
          end else begin
            if (c == NL) next_line();
            push_token(KIND_STRING, c, 1'b1, 64'd0, 1'b0);
          end
          return;
        end
        MODE_ESC: begin
          case (c)
            "n": ch = NL;
            "r": ch = CR;
            "f": ch = FF;
            "t": ch = TAB;
            default: begin
              ch = c;
              if (c == NL) next_line();
            end
          endcase
          push_token(KIND_STRING, ch, 1'b1, 64'd0, 1'b0);
          mode = MODE_STR;
          return;
        end
        MODE_SLASH: begin
          if (c == "/") begin
            mode = MODE_CMT;
            return;
          end
        end
        MODE_CMT: begin
          if (c == NL) begin
            next_line();
            mode = MODE_IDLE;
          end
          return;
        end
        default: mode = MODE_IDLE;
      endcase
      // the byte ends the pending token and is lexed again from idle
      close_token();
      open_token(c);
    endfunction

    local function string describe(out_item_t t);
      return $sformatf("kind %0d char %02h valid %0b value %016h line %0d end %0b",
                       t.token_kind, t.token_char, t.char_valid, t.number_value,
                       t.line_number, t.token_end);
    endfunction

    function void check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        failures++;
        if (failures <= 10) $display("token with nothing due: %s", describe(got));
        return;
      end
      want = expected_tokens.pop_front();
      if (want.token_kind !== got.token_kind || want.token_char !== got.token_char ||
          want.char_valid !== got.char_valid || want.number_value !== got.number_value ||
          want.line_number !== got.line_number || want.token_end !== got.token_end) begin
        failures++;
        if (failures <= 10) begin
          $display("token mismatch, expected %s", describe(want));
          $display("                actual   %s", describe(got));
        end
      end
    endfunction

    function void check_drained();
      if (expected_tokens.size() != 0) begin
        failures++;
        $display("%0d expected tokens never came out", expected_tokens.size());
      end
    endfunction
  endclass

endpackage

### dv/tb_config_text_tokenizer_core.sv
`timescale 1ns / 100ps
// tb_config_text_tokenizer_core: self-checking testbench of the config text lexer
// directed text then random token fragments, all results checked by the scoreboard
// depends on ctt_pkg, ctt_check_pkg and config_text_tokenizer_core
module tb_config_text_tokenizer_core;
  import ctt_pkg::*;
  import ctt_check_pkg::*;

  localparam int HALF_PERIOD     = 5;
  // narrow line counter so that saturation is reached within the run
  localparam int LINE_BITS       = 8;
  localparam int RANDOM_ITEMS    = 800;
  localparam int HOLD_OFF_CYCLES = 80;
  // cycles without any transfer before the run is declared hung; the longest
  // legal quiet stretch is a receiver hold-off plus a couple of idle draws
  localparam int IDLE_LIMIT      = 2000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  token_scoreboard tokens;
  in_item_t        text_q[$];     // bytes of the fragment being sent
  int              quiet_cycles = 0;

  config_text_tokenizer_core #(
    .LINE_COUNT_BITS(LINE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // both channels are sampled at the rising edge; inputs only move on the
  // falling edge, so every value seen here is settled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tokens.note_byte(in_data);
      if (out_valid && !out_stall) tokens.check_token(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: nothing moved for far longer than any correct run allows
  always @(posedge clk) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("config_text_tokenizer_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // text building
  // ---------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b);
    in_item_t it;
    it.text_byte   = b;
    it.end_of_text = 1'b0;
    text_q.push_back(it);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  // end-of-text transfer; the byte field carries junk that must be ignored
  function automatic void put_end();
    in_item_t it;
    it.text_byte   = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    text_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic void put_identifier();
    int len;
    case ($urandom_range(0, 11))
      0: put_text("true");
      1: put_text("false");
      2: put_text("tru");
      3: put_text("falsey");
      4: put_text("trUe");
      5: put_text("fals");
      default: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
        put_byte(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
        for (int i = 0; i < len; i++)
          put_byte(pick_char("aeftrlsuxzAEFTZ_-0123456789"));
      end
    endcase
  endfunction

  // mostly short numbers, some long enough to wrap past 2^64
  function automatic void put_decimal();
    int len;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 4);
    for (int i = 0; i < len; i++) put_byte(pick_char("0123456789"));
  endfunction

  // zero digits after the prefix makes an error token
  function automatic void put_hex();
    int len;
    put_byte("0");
    put_byte($urandom_range(0, 1) ? "x" : "X");
    case ($urandom_range(0, 7))
      0:       len = 0;
      1:       len = $urandom_range(15, 20);
      default: len = $urandom_range(1, 6);
    endcase
    for (int i = 0; i < len; i++) put_byte(pick_char("0123456789abcdefABCDEF"));
  endfunction

  function automatic void put_string();
    int         len;
    logic [7:0] b;
    put_byte("\"");
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          put_byte("\\");
          put_byte(pick_char("nrft\"\\\nqa0"));
        end
        2: put_byte("\n");
        3: begin
          // any byte at all after an escape
          put_byte("\\");
          put_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          b = 8'($urandom_range(0, 255));
          if (b == "\"" || b == "\\") put_byte("\\");
          put_byte(b);
        end
      endcase
    end
    // an unclosed string runs on into the next fragment
    if ($urandom_range(0, 7) != 0) put_byte("\"");
  endfunction

  function automatic void put_comment();
    int len;
    put_text("//");
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
    put_byte("\n");
  endfunction

  // one random fragment into text_q
  function automatic void build_fragment();
    int roll;
    int run;
    roll = $urandom_range(0, 99);
    if (roll < 22) put_identifier();
    else if (roll < 34) put_decimal();
    else if (roll < 44) put_hex();
    else if (roll < 60) put_string();
    else if (roll < 70) put_byte(pick_char("{}:,[]<>+-*()/"));
    else if (roll < 76) put_comment();
    else if (roll < 91 && roll >= 84) put_byte(8'($urandom_range(0, 255)));
    else if (roll < 95 && roll >= 91) put_end();
    else if (roll < 84) begin
      put_byte(pick_char(" \t\r\n"));
    end else begin
      // long blank stretch pushes the line counter toward saturation
      run = $urandom_range(20, 60);
      for (int i = 0; i < run; i++) put_byte("\n");
    end
  endfunction

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------
  // sends text_q one transfer at a time; eager drops the idle gaps so that
  // bytes arrive back to back
  task automatic send_text(bit eager);
    int gap;
    foreach (text_q[i]) begin
      gap = eager ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= text_q[i];
      do @(posedge clk); while (in_stall);
      @(negedge clk);
    end
  endtask

  // result side: a random stall before each transfer, calm stretches with
  // none, and now and then a long hold-off so the result queue fills and the
  // input side has to stall
  initial begin
    int wait_cycles;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken % 250 == 120) wait_cycles = HOLD_OFF_CYCLES;
      else wait_cycles = calm ? 0 : $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int counted;
    tokens  = new(LINE_BITS);
    counted = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed text:
    //   "true//x\n"  exact keyword closed by a slash that opens a comment,
    //                newline at the comment end counted
    //   "07/a"       leading zero ended by a digit, lone slash before a letter
    //   0x00         byte zero closes the identifier and is an error
    //   "0x" 0xff    prefix without digits, then the top byte value as error
    //   "0xF\"\\q\n" hex closed by a quote, escaped letter, newline in string
    //   end          unterminated string flushed
    text_q.delete();
    put_text("true//x\n");
    put_text("07/a");
    put_byte(8'h00);
    put_text("0x");
    put_byte(8'hFF);
    put_text("0xF\"\\q\n");
    put_end();
    send_text(1'b0);

    // random fragments, some stretches sent with no gaps at all
    while (counted < RANDOM_ITEMS) begin
      text_q.delete();
      build_fragment();
      counted += text_q.size();
      send_text($urandom_range(0, 3) == 0);
    end
    text_q.delete();
    put_end();
    send_text(1'b0);
    in_valid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (tokens.pending() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
    tokens.check_drained();
    if (tokens.failures == 0) $display("config_text_tokenizer_core regression: pass");
    else $display("config_text_tokenizer_core regression: fail");
    $finish;
  end

endmodule

### config_text_tokenizer_core.f
rtl/core/ctt_pkg.sv
rtl/core/ctt_lex.sv
rtl/core/ctt_queue.sv
rtl/core/config_text_tokenizer_core.sv
dv/ctt_check_pkg.sv
dv/tb_config_text_tokenizer_core.sv
